FILE: hw/rtl/xsid_pkg.sv
package xsid_pkg;

	// Kind of a decoded instruction record.
	typedef enum logic [3:0] {
		KIND_MOV     = 4'd0,
		KIND_PUSH    = 4'd1,
		KIND_POP     = 4'd2,
		KIND_JMP     = 4'd3,
		KIND_JE      = 4'd4,
		KIND_JNE     = 4'd5,
		KIND_CALL    = 4'd6,
		KIND_NOP     = 4'd7,
		KIND_HLT     = 4'd8,
		KIND_WAIT    = 4'd9,
		KIND_F0      = 4'd10,
		KIND_F8      = 4'd11,
		KIND_RET     = 4'd12,
		KIND_SYSCALL = 4'd13,
		KIND_UNKNOWN = 4'd14
	} insn_kind_t;

	// Parser phase: waiting for an opcode or collecting operand bytes.
	typedef enum logic {
		PH_OPCODE,
		PH_OPERAND
	} parse_phase_t;

	localparam int OPERAND_W = 64;
	localparam int INSN_OFS_W = 32;

	// Opcode values.
	localparam logic [7:0] OP_MOV_LO  = 8'hB8;
	localparam logic [7:0] OP_MOV_HI  = 8'hBF;
	localparam logic [7:0] OP_PUSH_LO = 8'h50;
	localparam logic [7:0] OP_PUSH_HI = 8'h57;
	localparam logic [7:0] OP_POP_LO  = 8'h58;
	localparam logic [7:0] OP_POP_HI  = 8'h5F;
	localparam logic [7:0] OP_JMP     = 8'hE9;
	localparam logic [7:0] OP_CALL    = 8'hE8;
	localparam logic [7:0] OP_JE      = 8'h74;
	localparam logic [7:0] OP_JNE     = 8'h75;
	localparam logic [7:0] OP_ESC     = 8'h0F;
	localparam logic [7:0] OP_ESC2    = 8'h05;
	localparam logic [7:0] OP_NOP     = 8'h90;
	localparam logic [7:0] OP_HLT     = 8'hF4;
	localparam logic [7:0] OP_WAIT    = 8'h9B;
	localparam logic [7:0] OP_F0      = 8'hF0;
	localparam logic [7:0] OP_F8      = 8'hF8;
	localparam logic [7:0] OP_RET     = 8'hC3;
	localparam logic [7:0] OP_PAD     = 8'h00;
	localparam logic [7:0] OP_REX_LO  = 8'h40;
	localparam logic [7:0] OP_REX_HI  = 8'h4F;

	// Number of operand bytes that follow an opcode.
	function automatic logic [3:0] operand_len(input logic [7:0] op);
		logic [3:0] len;
		len = 4'd0;
		if (op >= OP_MOV_LO && op <= OP_MOV_HI) begin
			len = 4'd8;
		end else if (op == OP_JMP || op == OP_CALL) begin
			len = 4'd4;
		end else if (op == OP_JE || op == OP_JNE) begin
			len = 4'd1;
		end
		return len;
	endfunction

endpackage

FILE: hw/rtl/x86_subset_instruction_decoder.sv
// Byte-serial decoder for a small subset of x86-64 machine code.
// Input channel: one code byte per item, with stream_start marking the first
// byte of a new buffer (offset and parser restart before that byte is used).
// Output channel: one record (kind, register, operand, opcode offset) for
// each instruction that completes; prefix bytes, padding and operand bytes
// that do not finish an instruction give no record.
// Throughput is one byte per cycle while the receiver does not stall: the
// parser state is a handful of small registers updated once per byte, and
// the longest path is the 32-bit call target adder between the input register
// and the result register. An accepted byte is held in the input register
// and is then decoded into the result register, from which its record is
// offered.
// When the receiver stalls, the record holds in the result register and the
// byte behind it holds in the input register; code_stall rises only once
// both are full, so a byte can still be taken while a record waits.
// Reset (arst_n low) empties both registers and returns the parser to the
// opcode phase with the byte offset at zero.
module x86_subset_instruction_decoder #(
	parameter int OFFSET_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        code_valid,
	output logic        code_stall,
	input  logic [7:0]  code_byte,
	input  logic        stream_start,
	output logic        insn_valid,
	input  logic        insn_stall,
	output logic [3:0]  insn_kind,
	output logic [2:0]  reg_index,
	output logic [63:0] operand_value,
	output logic [31:0] insn_offset
);

	localparam int OW = xsid_pkg::OPERAND_W;
	localparam int IW = xsid_pkg::INSN_OFS_W;

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;

	// Parser state.
	xsid_pkg::parse_phase_t phase_q, phase_d;
	logic [7:0]             held_q, held_d;
	logic [3:0]             left_q, left_d;
	logic [OW-1:0]          acc_q, acc_d;
	logic [OFFSET_BITS-1:0] pos_q, pos_d;
	logic [IW-1:0]          oppos_q, oppos_d;
	logic                   esc_q, esc_d;

	// Decode signals.
	xsid_pkg::parse_phase_t phase_cur;
	logic [7:0]             held_cur;
	logic [3:0]             left_cur;
	logic [OW-1:0]          acc_cur;
	logic [OW-1:0]          acc_new;
	logic [OFFSET_BITS-1:0] here;
	logic                   esc_cur;
	logic                   skip;
	logic [3:0]             len;

	logic                   emit;
	xsid_pkg::insn_kind_t   kind;
	logic [2:0]             reg_sel;
	logic [OW-1:0]          operand;
	logic [IW-1:0]          offset;

	logic advance;
	logic consume;
	logic load;

	// Handshake: the pipeline moves when the result register is free or being taken.
	assign advance    = !insn_valid || !insn_stall;
	assign code_stall = valid_s1 && !advance;
	assign load       = code_valid && !code_stall;
	assign consume    = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_s1  <= code_byte;
			start_s1 <= stream_start;
		end
	end

	// A new stream clears the parser before its first byte is looked at.
	always_comb begin
		phase_cur = start_s1 ? xsid_pkg::PH_OPCODE : phase_q;
		held_cur  = start_s1 ? 8'h00 : held_q;
		left_cur  = start_s1 ? 4'd0 : left_q;
		acc_cur   = start_s1 ? '0 : acc_q;
		here      = start_s1 ? '0 : pos_q;
		esc_cur   = start_s1 ? 1'b0 : esc_q;
		acc_new   = {byte_s1, acc_cur[OW-1:8]};
		len       = xsid_pkg::operand_len(byte_s1);
		skip      = (esc_cur && byte_s1 == xsid_pkg::OP_ESC2) ||
		            byte_s1 == xsid_pkg::OP_PAD ||
		            (byte_s1 >= xsid_pkg::OP_REX_LO && byte_s1 <= xsid_pkg::OP_REX_HI);
	end

	// Next parser state.
	always_comb begin
		phase_d = phase_cur;
		held_d  = held_cur;
		left_d  = left_cur;
		acc_d   = acc_cur;
		pos_d   = here + 1'b1;
		oppos_d = oppos_q;
		esc_d   = esc_cur;
		unique case (phase_cur)
			xsid_pkg::PH_OPERAND: begin
				acc_d = acc_new;
				if (left_cur != 4'd0) begin
					left_d = left_cur - 4'd1;
				end
				if (left_cur <= 4'd1) begin
					phase_d = xsid_pkg::PH_OPCODE;
				end
			end
			xsid_pkg::PH_OPCODE: begin
				esc_d = 1'b0;
				if (!skip) begin
					oppos_d = IW'(here);
					if (len != 4'd0) begin
						held_d  = byte_s1;
						left_d  = len;
						acc_d   = '0;
						phase_d = xsid_pkg::PH_OPERAND;
					end else if (byte_s1 == xsid_pkg::OP_ESC) begin
						esc_d = 1'b1;
					end
				end
			end
			default: begin
				phase_d = xsid_pkg::PH_OPCODE;
			end
		endcase
	end

	// Record produced by this byte, if any.
	always_comb begin
		emit    = 1'b0;
		kind    = xsid_pkg::KIND_UNKNOWN;
		reg_sel = 3'd0;
		operand = '0;
		offset  = IW'(here);
		unique case (phase_cur)
			xsid_pkg::PH_OPERAND: begin
				emit   = left_cur <= 4'd1;
				offset = oppos_q;
				if (held_cur >= xsid_pkg::OP_MOV_LO && held_cur <= xsid_pkg::OP_MOV_HI) begin
					kind    = xsid_pkg::KIND_MOV;
					reg_sel = held_cur[2:0];
					operand = acc_new;
				end else if (held_cur == xsid_pkg::OP_JMP) begin
					kind    = xsid_pkg::KIND_JMP;
					operand = {32'd0, acc_new[63:32]};
				end else if (held_cur == xsid_pkg::OP_CALL) begin
					kind    = xsid_pkg::KIND_CALL;
					operand = {32'd0, oppos_q + 32'd5 + acc_new[63:32]};
				end else begin
					kind    = (held_cur == xsid_pkg::OP_JE) ? xsid_pkg::KIND_JE
					                                        : xsid_pkg::KIND_JNE;
					operand = {32'd0, {24{byte_s1[7]}}, byte_s1};
				end
			end
			xsid_pkg::PH_OPCODE: begin
				emit = !skip && len == 4'd0;
				unique case (byte_s1) inside
					[xsid_pkg::OP_PUSH_LO:xsid_pkg::OP_PUSH_HI]: begin
						kind    = xsid_pkg::KIND_PUSH;
						reg_sel = byte_s1[2:0];
					end
					[xsid_pkg::OP_POP_LO:xsid_pkg::OP_POP_HI]: begin
						kind    = xsid_pkg::KIND_POP;
						reg_sel = byte_s1[2:0];
					end
					xsid_pkg::OP_NOP:  kind = xsid_pkg::KIND_NOP;
					xsid_pkg::OP_HLT:  kind = xsid_pkg::KIND_HLT;
					xsid_pkg::OP_WAIT: kind = xsid_pkg::KIND_WAIT;
					xsid_pkg::OP_F0:   kind = xsid_pkg::KIND_F0;
					xsid_pkg::OP_F8:   kind = xsid_pkg::KIND_F8;
					xsid_pkg::OP_RET:  kind = xsid_pkg::KIND_RET;
					xsid_pkg::OP_ESC:  kind = xsid_pkg::KIND_SYSCALL;
					default:           kind = xsid_pkg::KIND_UNKNOWN;
				endcase
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// Parser registers advance once per consumed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= xsid_pkg::PH_OPCODE;
			held_q  <= 8'h00;
			left_q  <= 4'd0;
			acc_q   <= '0;
			pos_q   <= '0;
			oppos_q <= '0;
			esc_q   <= 1'b0;
		end else if (consume) begin
			phase_q <= phase_d;
			held_q  <= held_d;
			left_q  <= left_d;
			acc_q   <= acc_d;
			pos_q   <= pos_d;
			oppos_q <= oppos_d;
			esc_q   <= esc_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			insn_valid <= 1'b0;
		end else if (advance) begin
			insn_valid <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && emit) begin
			insn_kind     <= kind;
			reg_index     <= reg_sel;
			operand_value <= operand;
			insn_offset   <= offset;
		end
	end

endmodule

FILE: hw/rtl/xsid_checker.sv
module xsid_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        code_valid,
	input logic        code_stall,
	input logic [7:0]  code_byte,
	input logic        stream_start,
	input logic        insn_valid,
	input logic        insn_stall,
	input logic [3:0]  insn_kind,
	input logic [2:0]  reg_index,
	input logic [63:0] operand_value,
	input logic [31:0] insn_offset
);

	// A waiting record stays offered while the receiver stalls.
	assert property (@(posedge clk) disable iff (!arst_n)
		insn_valid && insn_stall |=> insn_valid)
		else $error("record dropped while stalled");

	// The input side only backs up when a record is stuck at the output.
	assert property (@(posedge clk) disable iff (!arst_n)
		code_stall |-> insn_valid && insn_stall)
		else $error("input stalled without a blocked record");

	// Only mov, push and pop carry a register number.
	assert property (@(posedge clk) disable iff (!arst_n)
		insn_valid && insn_kind != xsid_pkg::KIND_MOV && insn_kind != xsid_pkg::KIND_PUSH &&
		insn_kind != xsid_pkg::KIND_POP |-> reg_index == 3'd0)
		else $error("register set on a kind without one");

	// Only mov carries a value wider than 32 bits.
	assert property (@(posedge clk) disable iff (!arst_n)
		insn_valid && insn_kind != xsid_pkg::KIND_MOV |-> operand_value[63:32] == 32'd0)
		else $error("wide operand on a non-mov record");

	// Kinds without an operand report zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		insn_valid && insn_kind >= xsid_pkg::KIND_PUSH && insn_kind != xsid_pkg::KIND_JMP &&
		insn_kind != xsid_pkg::KIND_JE && insn_kind != xsid_pkg::KIND_JNE &&
		insn_kind != xsid_pkg::KIND_CALL |-> operand_value == 64'd0)
		else $error("operand set on a kind without one");

endmodule

bind x86_subset_instruction_decoder xsid_checker u_xsid_checker (.*);
